// ===== hw/rtl/afx_pkg.sv =====
// Shared types and constants for the ADTS frame extractor.
// No dependencies; imported by afx_res_fifo and adts_frame_extractor_unit.
package afx_pkg;

    // parser mode
    typedef enum logic [1:0] {
        MODE_HUNT  = 2'd0,
        MODE_FRAME = 2'd1,
        MODE_SKIP  = 2'd2
    } mode_t;

    // status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TRUNCATED = 3'd1,
        ST_NO_SYNC   = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_TOO_LONG  = 3'd4
    } status_t;

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       is_last;
        status_t    status;
    } result_t;

    // register map
    localparam int          APB_ADDR_W       = 3;
    localparam int          APB_DATA_W       = 32;
    localparam logic [APB_ADDR_W-1:0] REG_MAX_FRAME = 3'd0;

    localparam int          LEN_W            = 13;
    localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 13'd5120;
    localparam logic [LEN_W-1:0] MIN_FRAME_LEN   = 13'd7;

    localparam logic [7:0]  SYNC_BYTE        = 8'hFF;
    localparam logic [3:0]  SYNC_NIBBLE      = 4'hF;

    // header byte positions holding the frame length
    localparam logic [LEN_W-1:0] POS_LEN_HI  = 13'd3;
    localparam logic [LEN_W-1:0] POS_LEN_MID = 13'd4;
    localparam logic [LEN_W-1:0] POS_LEN_LO  = 13'd5;
    localparam logic [LEN_W-1:0] POS_BODY    = 13'd6;

endpackage

// ===== hw/rtl/afx_res_fifo.sv =====
// Result queue for the ADTS frame extractor: takes up to two results a cycle,
// gives one a cycle while rd_ready is high. Depends on afx_pkg for the result type.
module afx_res_fifo
    import afx_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push0,
    input  logic    push1,
    input  result_t wdata0,
    input  result_t wdata1,
    output logic    room2,
    output logic    rd_valid,
    input  logic    rd_ready,
    output result_t rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - 2);

    result_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  wr_ptr_plus1;
    logic [PTR_W-1:0]  wr_first;
    logic [PTR_W-1:0]  wr_second;
    logic              pop;
    logic [1:0]        n_push;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    assign pop      = rd_valid && rd_ready;
    assign rd_valid = (count_reg != '0);
    assign rdata    = mem_reg[rd_ptr_reg];
    assign room2    = (count_reg <= ROOM_LIMIT);
    assign n_push   = {1'b0, push0} + {1'b0, push1};

    // slot addresses for the one or two writes
    always_comb
    begin
        wr_ptr_plus1 = ptr_inc(wr_ptr_reg);
        wr_first     = wr_ptr_reg;
        wr_second    = push0 ? wr_ptr_plus1 : wr_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        if (n_push == 2'd2)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_plus1);
        end
        else if (n_push == 2'd1)
        begin
            wr_ptr_next = wr_ptr_plus1;
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(n_push) - CNT_W'(pop);
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            mem_reg[wr_first] <= wdata0;
        end
        if (push1)
        begin
            mem_reg[wr_second] <= wdata1;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/adts_frame_extractor_unit.sv =====
// ADTS frame extractor top level: byte parser, config register, result queue.
// Depends on afx_pkg and afx_res_fifo.
//
// Takes one buffer byte per cycle and never stalls the input while the result
// side keeps up. Each byte is parsed in the cycle it is accepted and its
// results go into a RES_DEPTH-entry result queue that drives the output.
// A sync byte gives two results (the held 0xFF and the current byte); every
// other byte gives at most one, so the output hands out that byte's two results one after the other.
// in_ready is high while the queue has room for two results; results are written
// into the queue when the byte is accepted. max_frame_bytes is at byte address 0
// and should be written only while the block is idle.
module adts_frame_extractor_unit
    import afx_pkg::*;
#(
    parameter int RES_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // input bytes
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  buffer_end,
    // results
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  has_byte,
    output logic                  is_last,
    output logic [2:0]            status
);

    logic [LEN_W-1:0] max_frame_reg;
    mode_t            mode_reg, mode_next;
    logic             prev_ff_reg, prev_ff_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0] flen_reg, flen_next;

    logic             in_take;
    logic             room2;
    logic             push0, push1;
    result_t          res0, res1, head;
    logic             sync_hit;
    logic             in_frame;
    logic [LEN_W-1:0] p;
    logic [LEN_W-1:0] fl_cur;
    logic [LEN_W-1:0] fl_new;
    logic [LEN_W:0]   p_plus1;
    logic             last;
    status_t          st;

    assign in_take = in_valid && in_ready;
    assign in_ready = room2;

    // config register write and readback
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg <= MAX_FRAME_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_MAX_FRAME))
        begin
            max_frame_reg <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = (paddr == REG_MAX_FRAME) ? {{(APB_DATA_W-LEN_W){1'b0}}, max_frame_reg}
                                             : '0;

    // sync detect and frame byte position
    always_comb
    begin
        sync_hit = (mode_reg != MODE_FRAME) && (mode_reg != MODE_SKIP) && prev_ff_reg
                   && (data_byte[7:4] == SYNC_NIBBLE);
        in_frame = (mode_reg == MODE_FRAME) || sync_hit;
        p        = sync_hit ? LEN_W'(1) : pos_reg;
        fl_cur   = sync_hit ? '0 : flen_reg;
        p_plus1  = {1'b0, p} + 1'b1;
    end

    // frame length assembly and end-of-frame checks
    always_comb
    begin
        fl_new = fl_cur;
        if (p == POS_LEN_HI)
        begin
            fl_new = {data_byte[1:0], 11'd0};
        end
        else if (p == POS_LEN_MID)
        begin
            fl_new = fl_cur | {2'd0, data_byte, 3'd0};
        end
        else if (p == POS_LEN_LO)
        begin
            fl_new = fl_cur | {10'd0, data_byte[7:5]};
        end

        last = 1'b0;
        st   = ST_OK;
        if (p == POS_LEN_LO)
        begin
            if (fl_new < MIN_FRAME_LEN)
            begin
                last = 1'b1;
                st   = ST_BAD_LEN;
            end
            else if (fl_new > max_frame_reg)
            begin
                last = 1'b1;
                st   = ST_TOO_LONG;
            end
        end
        else if ((p >= POS_BODY) && (p_plus1 == {1'b0, fl_new}))
        begin
            last = 1'b1;
        end
        if (!last && buffer_end)
        begin
            last = 1'b1;
            st   = ST_TRUNCATED;
        end
    end

    // next state and results
    always_comb
    begin
        mode_next    = mode_reg;
        prev_ff_next = prev_ff_reg;
        pos_next     = pos_reg;
        flen_next    = flen_reg;
        push0        = 1'b0;
        push1        = 1'b0;
        res0         = '{out_byte: SYNC_BYTE, has_byte: 1'b1, is_last: 1'b0, status: ST_OK};
        res1         = '{out_byte: data_byte, has_byte: 1'b1, is_last: last, status: st};

        if (in_take)
        begin
            case (mode_reg)
                MODE_SKIP:
                begin
                    if (buffer_end)
                    begin
                        mode_next = MODE_HUNT;
                        prev_ff_next = 1'b0;
                        pos_next = '0;
                        flen_next = '0;
                    end
                end
                default:
                begin
                    if (in_frame)
                    begin
                        push0        = sync_hit;
                        push1        = 1'b1;
                        prev_ff_next = 1'b0;
                        if (buffer_end)
                        begin
                            mode_next = MODE_HUNT;
                            pos_next  = '0;
                            flen_next = '0;
                        end
                        else
                        begin
                            mode_next = last ? MODE_SKIP : MODE_FRAME;
                            pos_next  = p_plus1[LEN_W-1:0];
                            flen_next = fl_new;
                        end
                    end
                    else
                    begin
                        // still hunting
                        prev_ff_next = (data_byte == SYNC_BYTE);
                        if (buffer_end)
                        begin
                            push1 = 1'b1;
                            res1  = '{out_byte: 8'd0, has_byte: 1'b0, is_last: 1'b1,
                                      status: ST_NO_SYNC};
                            mode_next    = MODE_HUNT;
                            prev_ff_next = 1'b0;
                            pos_next     = '0;
                            flen_next    = '0;
                        end
                    end
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_HUNT;
            prev_ff_reg <= 1'b0;
            pos_reg     <= '0;
            flen_reg    <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            prev_ff_reg <= prev_ff_next;
            pos_reg     <= pos_next;
            flen_reg    <= flen_next;
        end
    end

    // result queue
    afx_res_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push0    (push0),
        .push1    (push1),
        .wdata0   (res0),
        .wdata1   (res1),
        .room2    (room2),
        .rd_valid (out_valid),
        .rd_ready (out_ready),
        .rdata    (head)
    );

    assign out_byte = head.out_byte;
    assign has_byte = head.has_byte;
    assign is_last  = head.is_last;
    assign status   = head.status;

endmodule

// ===== dv/adts_frame_extractor_unit_test.sv =====
// Self-checking testbench for adts_frame_extractor_unit: byte buffers in, frame bytes out.
// Depends on afx_pkg and the RTL; an in-bench parser predicts every result
// and a monitor compares the results field by field.
module adts_frame_extractor_unit_test;
    import afx_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_BYTES  = 190;
    localparam int MAX_BODY     = 64;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // configuration port
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = REG_MAX_FRAME;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // byte requests
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte = 8'h00;
    logic       buffer_end = 1'b0;

    // results
    logic       out_valid;
    logic       out_ready = 1'b1;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       is_last;
    logic [2:0] status;

    // parser state mirrored in the bench
    mode_t            parse_mode = MODE_HUNT;
    logic             held_ff = 1'b0;
    logic [LEN_W-1:0] frame_pos = '0;
    logic [LEN_W-1:0] frame_len = '0;
    logic [LEN_W-1:0] max_frame_limit = MAX_FRAME_RESET;

    result_t    frame_results_due[$];
    logic [7:0] buffer_bytes[$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int bytes_sent = 0;
    int mismatch_count = 0;
    int stall_cycles = 0;

    adts_frame_extractor_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .buffer_end (buffer_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .has_byte   (has_byte),
        .is_last    (is_last),
        .status     (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void expect_result(input logic [7:0] b, input logic has,
                                          input logic last, input status_t st);
        result_t r;
        r.out_byte = b;
        r.has_byte = has;
        r.is_last  = last;
        r.status   = st;
        frame_results_due.push_back(r);
    endfunction

    function automatic void restart_hunt();
        parse_mode = MODE_HUNT;
        held_ff    = 1'b0;
        frame_pos  = '0;
        frame_len  = '0;
    endfunction

    // advance the mirrored parser by one accepted byte
    function automatic void extract_frame_byte(input logic [7:0] d, input logic last_of_buf);
        logic [LEN_W-1:0] pos;
        logic             done;
        status_t          st;
        if (parse_mode == MODE_SKIP)
        begin
            if (last_of_buf)
                restart_hunt();
            return;
        end
        if (parse_mode != MODE_FRAME)
        begin
            if (held_ff && d[7:4] == SYNC_NIBBLE)
            begin
                // sync found: the held 0xff goes out first
                expect_result(SYNC_BYTE, 1'b1, 1'b0, ST_OK);
                parse_mode = MODE_FRAME;
                held_ff    = 1'b0;
                frame_pos  = 13'd1;
                frame_len  = '0;
            end
            else
            begin
                held_ff = (d == SYNC_BYTE);
                if (last_of_buf)
                begin
                    expect_result(8'h00, 1'b0, 1'b1, ST_NO_SYNC);
                    restart_hunt();
                end
                return;
            end
        end
        // length field spread over header bytes 3 to 5
        pos = frame_pos;
        if (pos == POS_LEN_HI)
            frame_len = {d[1:0], 11'd0};
        else if (pos == POS_LEN_MID)
            frame_len = frame_len | {2'b00, d, 3'b000};
        else if (pos == POS_LEN_LO)
            frame_len = frame_len | {10'd0, d[7:5]};
        frame_pos = pos + 13'd1;
        done = 1'b0;
        st   = ST_OK;
        if (pos == POS_LEN_LO)
        begin
            if (frame_len < MIN_FRAME_LEN)
            begin
                done = 1'b1;
                st   = ST_BAD_LEN;
            end
            else if (frame_len > max_frame_limit)
            begin
                done = 1'b1;
                st   = ST_TOO_LONG;
            end
        end
        else if (pos >= POS_BODY && {1'b0, pos} + 14'd1 == {1'b0, frame_len})
        begin
            done = 1'b1;
        end
        if (!done && last_of_buf)
        begin
            done = 1'b1;
            st   = ST_TRUNCATED;
        end
        expect_result(d, 1'b1, done, st);
        if (last_of_buf)
            restart_hunt();
        else if (done)
            parse_mode = MODE_SKIP;
    endfunction

    function automatic logic [7:0] any_byte();
        any_byte = ($urandom_range(3) == 0) ? SYNC_BYTE : 8'($urandom);
    endfunction

    // one byte request, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] d, input logic last_of_buf);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid   <= 1'b1;
        data_byte  <= d;
        buffer_end <= last_of_buf;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        extract_frame_byte(d, last_of_buf);
    endtask

    task automatic send_buffer();
        foreach (buffer_bytes[i])
            send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
        buffer_bytes.delete();
    endtask

    // hold off requests until every predicted result has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        while (frame_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // setup and access cycle; upper data bits carry noise
    task automatic write_max_frame(input logic [LEN_W-1:0] limit);
        logic [31:0] noise;
        noise = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MAX_FRAME;
        pwdata  <= {noise[APB_DATA_W-1:LEN_W], limit};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        max_frame_limit = limit;
    endtask

    // mostly well-formed frames with random content, some noise buffers
    task automatic send_random_buffer();
        logic [LEN_W-1:0] flen;
        int               frame_bytes;
        int               len_cap;
        logic [7:0]       len_hi;
        logic [7:0]       len_lo;
        buffer_bytes.delete();
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 12)) buffer_bytes.push_back(any_byte());
        end
        else
        begin
            repeat ($urandom_range(0, 3)) buffer_bytes.push_back(any_byte());
            len_cap = (max_frame_limit < 13'd40) ? int'(max_frame_limit) : 40;
            case ($urandom_range(9))
                0: flen = 13'($urandom_range(0, 6));
                1: flen = (max_frame_limit > 13'd8189) ? max_frame_limit
                        : max_frame_limit + 13'($urandom_range(0, 2));
                2: flen = 13'($urandom_range(7, 8191));
                default: flen = 13'($urandom_range(7, len_cap));
            endcase
            len_hi      = 8'($urandom);
            len_hi[1:0] = flen[12:11];
            len_lo      = 8'($urandom);
            len_lo[7:5] = flen[2:0];
            buffer_bytes.push_back(SYNC_BYTE);
            buffer_bytes.push_back({SYNC_NIBBLE, 4'($urandom)});
            buffer_bytes.push_back(8'($urandom));
            buffer_bytes.push_back(len_hi);
            buffer_bytes.push_back(flen[10:3]);
            buffer_bytes.push_back(len_lo);
            frame_bytes = (flen >= MIN_FRAME_LEN && flen <= max_frame_limit) ? int'(flen) : 6;
            // long frames get cut short by the buffer end
            repeat ((frame_bytes > MAX_BODY ? MAX_BODY : frame_bytes) - 6)
                buffer_bytes.push_back(8'($urandom));
            case ($urandom_range(5))
                0: repeat ($urandom_range(0, 5)) void'(buffer_bytes.pop_back());
                1: repeat ($urandom_range(1, 4)) buffer_bytes.push_back(any_byte());
                default: ;
            endcase
        end
        send_buffer();
    endtask

    task automatic test_directed_cases();
        // buffer with no sync
        buffer_bytes = '{8'h00};
        send_buffer();
        // sync on the last byte
        buffer_bytes = '{8'hFF, 8'hF1};
        send_buffer();
        // broken sync, then a seven byte frame ending with the buffer
        buffer_bytes = '{8'h12, 8'hFF, 8'h7F, 8'hFF, 8'hF9, 8'h3C, 8'h00, 8'h00, 8'hE0, 8'hA5};
        send_buffer();
        // length six, rest of buffer ignored
        buffer_bytes = '{8'hFF, 8'hF0, 8'h00, 8'h00, 8'h00, 8'hC0, 8'h66, 8'h77};
        send_buffer();
        // largest length against the reset limit, buffer ends on byte 5
        buffer_bytes = '{8'hFF, 8'hF1, 8'h00, 8'h03, 8'hFF, 8'hFF};
        send_buffer();
    endtask

    task automatic test_length_limits();
        drain_results();
        write_max_frame(MIN_FRAME_LEN);
        buffer_bytes = '{8'hFF, 8'hF0, 8'h5A, 8'h00, 8'h00, 8'hE0, 8'h42};
        send_buffer();
        buffer_bytes = '{8'hFF, 8'hF2, 8'h00, 8'h00, 8'h01, 8'h00, 8'h33};
        send_buffer();
        drain_results();
        write_max_frame(13'd8191);
        buffer_bytes = '{8'hFF, 8'hF0, 8'hAA, 8'h03, 8'hFF, 8'hFF, 8'h11};
        send_buffer();
    endtask

    task automatic run_random_phase(input int send_idle, input int recv_stall,
                                    input logic [LEN_W-1:0] limit);
        int start_count;
        drain_results();
        write_max_frame(limit);
        sender_idle_pct    = send_idle;
        receiver_stall_pct = recv_stall;
        start_count = bytes_sent;
        while (bytes_sent - start_count < PHASE_BYTES)
        begin
            if ($urandom_range(24) == 0)
                drain_results();
            send_random_buffer();
        end
    endtask

    task automatic test_random_buffers();
        run_random_phase(0, 0, 13'd8191);
        run_random_phase(83, 0, 13'($urandom_range(7, 60)));
        run_random_phase(0, 83, MIN_FRAME_LEN);
        run_random_phase(22, 22, MAX_FRAME_RESET);
    endtask

    // result monitor and receiver stalls
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_results_due.size() == 0)
            begin
                $error("unexpected result: out_byte %0h has_byte %0d is_last %0d status %0d",
                       out_byte, has_byte, is_last, status);
                mismatch_count++;
            end
            else
            begin
                want = frame_results_due.pop_front();
                if (out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, out_byte);
                    mismatch_count++;
                end
                if (has_byte !== want.has_byte)
                begin
                    $error("has_byte: expected %0d, got %0d", want.has_byte, has_byte);
                    mismatch_count++;
                end
                if (is_last !== want.is_last)
                begin
                    $error("is_last: expected %0d, got %0d", want.is_last, is_last);
                    mismatch_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatch_count++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_length_limits();
        test_random_buffers();
        drain_results();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
